// File: hdl/slrp_pkg.sv
// ----------------------------------------------------------------------------
// slrp_pkg
// Shared widths, constants and beat types for the signed limb repacker.
// ----------------------------------------------------------------------------
package slrp_pkg;

    localparam int LIMB_BITS = 30;
    localparam int WORD_BITS = 64;
    localparam int MAX_OUT   = 4;
    localparam int RES_BITS  = LIMB_BITS - 1;
    localparam int BUF_BITS  = RES_BITS + WORD_BITS;
    localparam int AVAIL_W   = $clog2(BUF_BITS + 1);
    localparam int NB_W      = $clog2(WORD_BITS + 1);
    localparam int RC_W      = $clog2(LIMB_BITS);
    localparam int SLOT_W    = $clog2(MAX_OUT + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // input beat
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 final_word;
        logic                 negative;
    } t_in;

    // output beat
    typedef struct packed {
        logic [LIMB_BITS-1:0] limb;
        logic                 last_limb;
    } t_out;

    // classified word handed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 fin;
        logic                 neg;
        logic [NB_W-1:0]      nb;
    } t_entry;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

// File: hdl/slrp_front.sv
// ----------------------------------------------------------------------------
// slrp_front
// Accepts input beats and classifies each word by its count of significant
// bits before handing it to the queue.
// ----------------------------------------------------------------------------
module slrp_front (
    input  logic           i_valid,
    input  slrp_pkg::t_in  i_data,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output slrp_pkg::t_entry o_entry
);
    import slrp_pkg::*;

    localparam int GROUPS = WORD_BITS / 8;

    // find the bit length of a word, one byte group at a time
    function automatic logic [NB_W-1:0] f_bit_length(input logic [WORD_BITS-1:0] w);
        logic [NB_W-1:0] len;
        logic [3:0]      blen;
        len = '0;
        for (int g = 0; g < GROUPS; g++) begin
            blen = '0;
            for (int b = 0; b < 8; b++) begin
                if (w[g*8+b]) begin
                    blen = 4'(b + 1);
                end
            end
            if (blen != 4'd0) begin
                len = NB_W'(g * 8) + NB_W'(blen);
            end
        end
        return len;
    endfunction

    // accept when the queue has room
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // classify: a final word counts only up to its highest set bit
    always_comb begin
        o_entry.word = i_data.word;
        o_entry.fin  = i_data.final_word;
        o_entry.neg  = i_data.negative;
        o_entry.nb   = i_data.final_word ? f_bit_length(i_data.word) : NB_W'(WORD_BITS);
    end

endmodule

// File: hdl/slrp_queue.sv
// ----------------------------------------------------------------------------
// slrp_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module slrp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slrp_pkg::t_entry i_entry,
    input  logic             i_pop,
    output slrp_pkg::t_q_status o_status,
    output slrp_pkg::t_entry o_entry
);
    import slrp_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && o_status.valid;
    assign o_entry        = r_mem[r_rd_ptr];

    // store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/slrp_back.sv
// ----------------------------------------------------------------------------
// slrp_back
// Slices queued words into limbs, negates them for negative numbers and
// emits the sign limb through a holding register, one queued word at a time.
// ----------------------------------------------------------------------------
module slrp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slrp_pkg::t_q_status i_q_status,
    input  slrp_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output slrp_pkg::t_out   o_data
);
    import slrp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PEND,
        S_RUN
    } t_bstate;

    t_bstate              r_state;
    logic [BUF_BITS-1:0]  r_buf;
    logic [AVAIL_W-1:0]   r_avail;
    logic                 r_fin;
    logic [SLOT_W-1:0]    r_slots;
    logic [RES_BITS-1:0]  r_res_bits;
    logic [RC_W-1:0]      r_res_cnt;
    logic                 r_carry;
    logic                 r_sign;
    logic                 r_at_first;
    logic                 r_sign_pending;
    logic                 r_pending_neg;
    logic                 r_ovalid;
    t_out                 r_odata;

    logic                 w_out_free;
    logic                 w_first;
    logic [RC_W-1:0]      w_rc;
    logic [RES_BITS-1:0]  w_res;
    logic [BUF_BITS-1:0]  n_buf;
    logic [AVAIL_W-1:0]   n_avail;
    logic [BUF_BITS-1:0]  w_shift_buf;
    logic [AVAIL_W-1:0]   w_shift_avail;
    logic                 w_have_limb;
    logic                 w_more;
    logic [LIMB_BITS-1:0] w_raw;
    logic [LIMB_BITS-1:0] w_limb;
    logic                 w_slot_free;
    logic                 w_emit;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && i_q_status.valid;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;

    // merge residue with the incoming word
    always_comb begin
        w_first = r_at_first;
        w_rc    = w_first ? '0 : r_res_cnt;
        w_res   = w_first ? '0 : r_res_bits;
        n_buf   = BUF_BITS'(w_res) | (BUF_BITS'(i_entry.word) << w_rc);
        n_avail = AVAIL_W'(w_rc) + AVAIL_W'(i_entry.nb);
    end

    // slice the next limb and negate it if needed
    always_comb begin
        w_have_limb   = r_fin ? (r_avail != '0) : (r_avail >= AVAIL_W'(LIMB_BITS));
        w_raw         = r_buf[LIMB_BITS-1:0];
        w_limb        = r_sign ? (~w_raw + LIMB_BITS'(r_carry)) : w_raw;
        w_shift_buf   = r_buf >> LIMB_BITS;
        w_shift_avail = (r_avail > AVAIL_W'(LIMB_BITS)) ?
                        (r_avail - AVAIL_W'(LIMB_BITS)) : '0;
        w_more        = r_fin ? (w_shift_avail != '0) :
                        (w_shift_avail >= AVAIL_W'(LIMB_BITS));
        w_slot_free   = (r_slots < SLOT_W'(MAX_OUT));
        w_emit        = (r_state == S_PEND) ||
                        ((r_state == S_RUN) && w_slot_free && (w_have_limb || r_fin));
    end

    // sequence one word: pending sign, data limbs, then sign or residue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_res_bits     <= '0;
            r_res_cnt      <= '0;
            r_carry        <= 1'b1;
            r_sign         <= 1'b0;
            r_at_first     <= 1'b1;
            r_sign_pending <= 1'b0;
            r_pending_neg  <= 1'b0;
            r_ovalid       <= 1'b0;
            r_slots        <= '0;
            r_fin          <= 1'b0;
        end else begin
            // load a new output beat, or drop the one taken
            if (w_out_free) begin
                r_ovalid <= w_emit;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_status.valid) begin
                        r_buf      <= n_buf;
                        r_avail    <= n_avail;
                        r_fin      <= i_entry.fin;
                        r_slots    <= '0;
                        r_at_first <= 1'b0;
                        if (w_first) begin
                            r_sign  <= i_entry.neg;
                            r_carry <= 1'b1;
                        end
                        r_state <= r_sign_pending ? S_PEND : S_RUN;
                    end
                end
                S_PEND: begin
                    if (w_out_free) begin
                        r_odata.limb      <= {LIMB_BITS{r_pending_neg}};
                        r_odata.last_limb <= 1'b1;
                        r_slots           <= r_slots + 1'b1;
                        r_sign_pending    <= 1'b0;
                        r_state           <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_out_free) begin
                        if (w_have_limb) begin
                            // emit a data limb, or drop it past the slot limit
                            if (w_slot_free) begin
                                r_odata.limb      <= w_limb;
                                r_odata.last_limb <= 1'b0;
                                r_slots           <= r_slots + 1'b1;
                            end
                            if (r_sign && (w_limb != '0)) begin
                                r_carry <= 1'b0;
                            end
                            r_buf   <= w_shift_buf;
                            r_avail <= w_shift_avail;
                            if (!r_fin && !w_more) begin
                                r_res_bits <= w_shift_buf[RES_BITS-1:0];
                                r_res_cnt  <= w_shift_avail[RC_W-1:0];
                                r_state    <= S_IDLE;
                            end
                        end else if (r_fin) begin
                            // close the number with its sign limb
                            if (w_slot_free) begin
                                r_odata.limb      <= {LIMB_BITS{r_sign}};
                                r_odata.last_limb <= 1'b1;
                            end else begin
                                r_sign_pending <= 1'b1;
                                r_pending_neg  <= r_sign;
                            end
                            r_res_bits <= '0;
                            r_res_cnt  <= '0;
                            r_at_first <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_res_bits <= r_buf[RES_BITS-1:0];
                            r_res_cnt  <= r_avail[RC_W-1:0];
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/signed_limb_repack_64_to_30_core.sv
// ----------------------------------------------------------------------------
// signed_limb_repack_64_to_30_core
// Repacks a signed big integer from 64-bit magnitude words into 30-bit
// two's complement limbs, ending each number with a sign limb.
// ----------------------------------------------------------------------------
// Words enter least significant first with final_word on the top word and
// negative sampled on the first word of each number. The front end accepts
// a word per cycle, while the queue has room, into a two-entry queue; the
// back end merges a word with the carried residue and then sends one output
// beat at a time, so a middle word yields two or three limbs and a final
// word up to four limbs plus the sign limb. The limb sequencer in the back
// end, with its single output register, sets the output pace. When a final
// word yields four data limbs its sign limb is held and sent ahead of the
// limbs of the next accepted word.
module signed_limb_repack_64_to_30_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  slrp_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output slrp_pkg::t_out  o_data
);
    import slrp_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_entry    w_front_entry;
    t_entry    w_q_entry;
    t_q_status w_q_status;

    // classify incoming words
    slrp_front u_front (
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (w_q_status.full),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_entry (w_front_entry)
    );

    // decouple intake from limb output
    slrp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_front_entry),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_entry  (w_q_entry)
    );

    // slice, negate and emit limbs
    slrp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_entry    (w_q_entry),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule
